// ----- rtl/core/lfu_replacement_table_assert.svh -----
// Assertion macros shared by the LFU replacement table RTL.
// Included by the modules that check their own invariants; no other dependencies.
`ifndef LFU_REPLACEMENT_TABLE_ASSERT_SVH
`define LFU_REPLACEMENT_TABLE_ASSERT_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define LFU_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lfu_replacement_table: invariant violated");
// Same-cycle implication.
`define LFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu_replacement_table: implication violated");
// Next-cycle implication.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu_replacement_table: sequence violated");
`else
`define LFU_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LFU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/lfu_pkg.sv -----
// Shared constants and controller/datapath command and status types for the
// LFU replacement table. No dependencies.
package lfu_pkg;

    localparam int LFU_ENTRIES    = 32;
    localparam int LFU_KEY_BITS   = 16;
    localparam int LFU_COUNT_BITS = 16;

    localparam int KEY_W   = 16;
    localparam int SLOT_W  = 5;
    localparam int CAP_W   = 6;
    localparam int STAMP_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/core/lfu_channels.sv -----
// Valid/ready channel interfaces for access items and result items.
// Depends on lfu_pkg for the field widths.
interface lfu_req_if;
    import lfu_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] access_key;

    modport source (output valid, output access_key, input ready);
    modport sink   (input valid, input access_key, output ready);
endinterface

interface lfu_rsp_if;
    import lfu_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [KEY_W-1:0]  evicted_key;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_key, output ready);
endinterface

// ----- rtl/core/lfu_replacement_table.sv -----
// Top level of the LFU replacement table: configuration register, controller
// and datapath. Depends on lfu_pkg, lfu_channels, lfu_cfg, lfu_ctrl and lfu_dp.
//
//  Channel  Dir  Handshake          Carries
//  i_req    in   valid/ready        access_key
//  o_rsp    out  valid/ready        hit, slot, evicted_valid, evicted_key
//  APB      in   psel/penable       capacity register at byte address 0
//
// Each item is handled in order: accept, a scan of every entry in the table memory
// through its single read port, a drain of the last read, and a commit that writes
// the update and loads the result register once that register is free.
// Reset clears the valid bits, occupancy and tick at once; there is no clearing pass.
// A result waiting in the output register does not hold off the next item; only
// the commit of that next item waits until the result has been taken.
module lfu_replacement_table #(
    parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lfu_req_if.sink                        i_req,
    lfu_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lfu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lfu_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lfu_pkg::*;

    localparam int OCC_W = $clog2(ENTRIES + 1);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [OCC_W-1:0] w_eff_cap;
    logic             w_in_ready;

    assign i_req.ready = w_in_ready;

    lfu_cfg #(
        .ENTRIES (ENTRIES)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_cap (w_eff_cap)
    );

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lfu_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_access_key (i_req.access_key),
        .i_eff_cap    (w_eff_cap),
        .o_rsp        (o_rsp)
    );

endmodule

// ----- rtl/core/lfu_cfg.sv -----
// APB-style configuration register holding the table capacity, and the
// clamped capacity seen by the datapath. Depends on lfu_pkg.
module lfu_cfg #(
    parameter int ENTRIES = lfu_pkg::LFU_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lfu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lfu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [$clog2(ENTRIES + 1)-1:0]    o_eff_cap
);
    import lfu_pkg::*;

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [CMP_W-1:0] cap_ext;
    logic             sel_cap;

    assign pready  = 1'b1;
    assign sel_cap = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && sel_cap) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_cap) begin
            prdata = APB_DATA_W'(r_capacity);
        end
    end

    // A capacity of zero behaves as one, and anything beyond the table size
    // behaves as the full table.
    assign cap_ext = CMP_W'(r_capacity);

    always_comb begin
        if (r_capacity == '0) begin
            o_eff_cap = OCC_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            o_eff_cap = OCC_W'(ENTRIES);
        end else begin
            o_eff_cap = OCC_W'(cap_ext);
        end
    end

endmodule

// ----- rtl/core/lfu_ctrl.sv -----
// Sequencing state machine for the LFU replacement table: accept, scan,
// drain the last read, commit. Depends on lfu_pkg.
`include "lfu_replacement_table_assert.svh"

module lfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lfu_pkg::t_dp_sts i_sts,
    output lfu_pkg::t_dp_cmd o_cmd
);
    import lfu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // The read of the final entry is still in flight.
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LFU_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SCAN)

endmodule

// ----- rtl/core/lfu_dp.sv -----
// Datapath of the LFU replacement table: entry memory, valid bits, scan
// registers, access tick, occupancy and result register. Depends on lfu_pkg
// and the result channel interface.
`include "lfu_replacement_table_assert.svh"

module lfu_dp #(
    parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lfu_pkg::t_dp_cmd               i_cmd,
    output lfu_pkg::t_dp_sts               o_sts,
    input  logic [lfu_pkg::KEY_W-1:0]      i_access_key,
    input  logic [$clog2(ENTRIES + 1)-1:0] i_eff_cap,
    lfu_rsp_if.source                      o_rsp
);
    import lfu_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = KEY_BITS + COUNT_BITS + STAMP_W;

    // Entry word: key, use count, insertion stamp.
    logic [WORD_W-1:0]     r_mem [ENTRIES];
    logic [WORD_W-1:0]     r_rd_word;

    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_eval_idx;
    logic                  r_eval_go;
    logic [ENTRIES-1:0]    r_valid;
    logic [OCC_W-1:0]      r_occ;
    logic [STAMP_W-1:0]    r_tick;
    logic [KEY_BITS-1:0]   r_key;

    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [STAMP_W-1:0]    r_hit_stamp;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_min_found;
    logic [IDX_W-1:0]      r_min_idx;
    logic [COUNT_BITS-1:0] r_min_cnt;
    logic [STAMP_W-1:0]    r_min_stamp;
    logic [KEY_BITS-1:0]   r_min_key;

    logic                  r_out_vld;
    logic                  r_o_hit;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_ev;
    logic [KEY_W-1:0]      r_o_ev_key;

    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [STAMP_W-1:0]    rd_stamp;
    logic                  rd_vld;
    logic                  rd_better;

    logic                  room;
    logic [IDX_W-1:0]      d_slot;
    logic [COUNT_BITS-1:0] d_cnt;
    logic [STAMP_W-1:0]    d_stamp;
    logic                  d_ev;
    logic [KEY_BITS-1:0]   d_ev_key;
    logic                  d_inc_occ;

    assign o_sts.scan_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_vld || o_rsp.ready;

    // Entry memory: one registered read a cycle during the scan, one write at commit.
    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[r_idx];
        if (i_cmd.commit) begin
            r_mem[d_slot] <= {r_key, d_cnt, d_stamp};
        end
    end

    assign rd_key   = r_rd_word[WORD_W-1 -: KEY_BITS];
    assign rd_cnt   = r_rd_word[STAMP_W +: COUNT_BITS];
    assign rd_stamp = r_rd_word[STAMP_W-1:0];
    assign rd_vld   = r_valid[r_eval_idx];

    // Lower count wins; equal counts go to the older stamp. Strict compares
    // keep the lowest slot when both are equal.
    assign rd_better = !r_min_found || (rd_cnt < r_min_cnt) ||
                       ((rd_cnt == r_min_cnt) && (rd_stamp < r_min_stamp));

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_idx;
        if (i_cmd.start) begin
            r_key <= KEY_BITS'(i_access_key);
        end
        if (r_eval_go) begin
            if (rd_vld && !r_hit && (rd_key == r_key)) begin
                r_hit_idx   <= r_eval_idx;
                r_hit_cnt   <= rd_cnt;
                r_hit_stamp <= rd_stamp;
            end
            if (!rd_vld && !r_free_found) begin
                r_free_idx <= r_eval_idx;
            end
            if (rd_vld && rd_better) begin
                r_min_idx   <= r_eval_idx;
                r_min_cnt   <= rd_cnt;
                r_min_stamp <= rd_stamp;
                r_min_key   <= rd_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_eval_go    <= 1'b0;
            r_tick       <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_min_found  <= 1'b0;
        end else begin
            r_eval_go <= i_cmd.scan;
            if (i_cmd.start) begin
                r_idx        <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_min_found  <= 1'b0;
                if (r_tick != '1) begin
                    r_tick <= r_tick + STAMP_W'(1);
                end
            end else begin
                if (i_cmd.scan) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (r_eval_go) begin
                    if (rd_vld && (rd_key == r_key)) begin
                        r_hit <= 1'b1;
                    end
                    if (!rd_vld) begin
                        r_free_found <= 1'b1;
                    end
                    if (rd_vld) begin
                        r_min_found <= 1'b1;
                    end
                end
            end
        end
    end

    assign room = (r_occ < i_eff_cap);

    always_comb begin
        d_slot    = '0;
        d_cnt     = COUNT_BITS'(1);
        d_stamp   = r_tick;
        d_ev      = 1'b0;
        d_ev_key  = '0;
        d_inc_occ = 1'b0;
        if (r_hit) begin
            d_slot  = r_hit_idx;
            d_cnt   = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + COUNT_BITS'(1);
            d_stamp = r_hit_stamp;
        end else if (room) begin
            d_slot    = r_free_found ? r_free_idx : '0;
            d_inc_occ = 1'b1;
        end else begin
            d_slot   = r_min_found ? r_min_idx : '0;
            d_ev     = r_min_found;
            d_ev_key = r_min_found ? r_min_key : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_occ     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid[d_slot] <= 1'b1;
                if (d_inc_occ) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_hit    <= r_hit;
            r_o_slot   <= SLOT_W'(d_slot);
            r_o_ev     <= d_ev;
            r_o_ev_key <= KEY_W'(d_ev_key);
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.hit           = r_o_hit;
    assign o_rsp.slot          = r_o_slot;
    assign o_rsp.evicted_valid = r_o_ev;
    assign o_rsp.evicted_key   = r_o_ev_key;

    `LFU_ASSERT_ALWAYS(a_occ_matches_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_occ))
    `LFU_ASSERT_IMPL(a_evict_only_on_miss, i_clk, i_rst_n, r_out_vld && r_o_ev, !r_o_hit)
    `LFU_ASSERT_NEXT(a_commit_loads_result, i_clk, i_rst_n, i_cmd.commit, r_out_vld)

endmodule
